// ----- rtl/core/ipv4_rhc_pkg.sv -----
package ipv4_rhc_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned COUNT_W   = 16;
   localparam int unsigned HDR_LEN_W = 6;
   localparam int unsigned ADDR_W    = 32;

   localparam logic [COUNT_W-1:0]   COUNT_MAX      = 16'hFFFF;
   localparam logic [COUNT_W-1:0]   MIN_HEADER     = 16'd20;
   localparam logic [COUNT_W-1:0]   CSUM_GOOD      = 16'hFFFF;
   localparam logic [COUNT_W-1:0]   IDX_TOTAL_HI   = 16'd2;
   localparam logic [COUNT_W-1:0]   IDX_TOTAL_LO   = 16'd3;
   localparam logic [COUNT_W-1:0]   IDX_PROTOCOL   = 16'd9;
   localparam logic [COUNT_W-1:0]   IDX_SRC_FIRST  = 16'd12;
   localparam logic [COUNT_W-1:0]   IDX_SRC_LAST   = 16'd15;

   localparam logic [BYTE_W-1:0] PROTO_ICMP = 8'd1;
   localparam logic [BYTE_W-1:0] PROTO_TCP  = 8'd6;
   localparam logic [BYTE_W-1:0] PROTO_UDP  = 8'd17;

   typedef enum logic [2:0] {
      VERDICT_ACCEPT    = 3'd0,
      VERDICT_SHORT     = 3'd1,
      VERDICT_BAD_IHL   = 3'd2,
      VERDICT_BAD_CSUM  = 3'd3,
      VERDICT_BAD_TOTAL = 3'd4
   } verdict_type;

   typedef enum logic [1:0] {
      CLASS_ICMP  = 2'd0,
      CLASS_UDP   = 2'd1,
      CLASS_TCP   = 2'd2,
      CLASS_OTHER = 2'd3
   } handler_class_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_payload_type;

   typedef struct packed {
      verdict_type          verdict;
      handler_class_type    handler_class;
      logic [BYTE_W-1:0]    protocol_number;
      logic [ADDR_W-1:0]    source_address;
      logic [HDR_LEN_W-1:0] payload_offset;
      logic [COUNT_W-1:0]   payload_length;
   } rsp_payload_type;

endpackage

// ----- rtl/core/ipv4_rhc_channels.sv -----
interface ipv4_rhc_req_if;
   import ipv4_rhc_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ipv4_rhc_rsp_if;
   import ipv4_rhc_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/ipv4_receive_header_check.sv -----
// Channel    Dir  Transaction
// req_chan   in   one packet byte (data_byte) with last_byte marking the final byte
// rsp_chan   out  one verdict per packet, on the transaction after the final byte
//
// One byte per cycle while no final byte is held. Each byte passes an input register,
// then a single stage that folds it into the running count, checksum and captured
// fields and fills the result register, from which the verdict is read. A final byte
// waits in the input register while the result register is full and unread; other
// bytes never wait. Reset is synchronous and clears all packet state.
module ipv4_receive_header_check (
   input logic           clock,
   input logic           reset,
   ipv4_rhc_req_if.sink  req_chan,
   ipv4_rhc_rsp_if.source rsp_chan
);
   import ipv4_rhc_pkg::*;

   logic                  in_valid_ff;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic                  in_last_ff;

   logic [COUNT_W-1:0]    byte_count_ff,   byte_count_in;
   logic [HDR_LEN_W-1:0]  header_bytes_ff, header_bytes_in;
   logic [COUNT_W-1:0]    checksum_ff,     checksum_in;
   logic [BYTE_W-1:0]     pending_ff,      pending_in;
   logic [COUNT_W-1:0]    total_ff,        total_in;
   logic [BYTE_W-1:0]     protocol_ff,     protocol_in;
   logic [ADDR_W-1:0]     source_ff,       source_in;

   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_payload_ff,  rsp_payload_in;

   logic                  out_free;
   logic                  process;
   logic [COUNT_W:0]      sum_wide;
   logic [COUNT_W-1:0]    sum_fold;
   logic [COUNT_W-1:0]    hdr_len_wide;
   logic [COUNT_W-1:0]    clamped_total;
   verdict_type           verdict;
   handler_class_type     handler_class;

   assign out_free      = !rsp_valid_ff || rsp_chan.ready;
   assign process       = in_valid_ff && (!in_last_ff || out_free);
   assign req_chan.ready = !in_valid_ff || process;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   always_comb begin
      header_bytes_in = header_bytes_ff;
      if (byte_count_ff == '0) begin
         header_bytes_in = {in_byte_ff[3:0], 2'b00};
      end
      hdr_len_wide = {{(COUNT_W-HDR_LEN_W){1'b0}}, header_bytes_in};

      sum_wide = {1'b0, checksum_ff} + {1'b0, pending_ff, in_byte_ff};
      sum_fold = sum_wide[COUNT_W] ? (sum_wide[COUNT_W-1:0] + 16'd1) : sum_wide[COUNT_W-1:0];

      pending_in  = pending_ff;
      checksum_in = checksum_ff;
      if (byte_count_ff < hdr_len_wide) begin
         if (!byte_count_ff[0]) begin
            pending_in = in_byte_ff;
         end else begin
            checksum_in = sum_fold;
         end
      end

      total_in    = total_ff;
      protocol_in = protocol_ff;
      source_in   = source_ff;
      if (byte_count_ff == IDX_TOTAL_HI) begin
         total_in = {in_byte_ff, total_ff[BYTE_W-1:0]};
      end else if (byte_count_ff == IDX_TOTAL_LO) begin
         total_in = {total_ff[COUNT_W-1:BYTE_W], in_byte_ff};
      end else if (byte_count_ff == IDX_PROTOCOL) begin
         protocol_in = in_byte_ff;
      end else if (byte_count_ff >= IDX_SRC_FIRST && byte_count_ff <= IDX_SRC_LAST) begin
         source_in = {source_ff[ADDR_W-BYTE_W-1:0], in_byte_ff};
      end

      byte_count_in = (byte_count_ff != COUNT_MAX) ? (byte_count_ff + 16'd1) : byte_count_ff;

      clamped_total = (total_in > byte_count_in) ? byte_count_in : total_in;

      if (byte_count_in < MIN_HEADER) begin
         verdict = VERDICT_SHORT;
      end else if (hdr_len_wide < MIN_HEADER || hdr_len_wide > byte_count_in) begin
         verdict = VERDICT_BAD_IHL;
      end else if (checksum_in != CSUM_GOOD) begin
         verdict = VERDICT_BAD_CSUM;
      end else if (clamped_total < hdr_len_wide) begin
         verdict = VERDICT_BAD_TOTAL;
      end else begin
         verdict = VERDICT_ACCEPT;
      end

      case (protocol_in)
         PROTO_ICMP: handler_class = CLASS_ICMP;
         PROTO_UDP:  handler_class = CLASS_UDP;
         PROTO_TCP:  handler_class = CLASS_TCP;
         default:    handler_class = CLASS_OTHER;
      endcase

      rsp_payload_in.verdict = verdict;
      if (verdict == VERDICT_ACCEPT) begin
         rsp_payload_in.handler_class   = handler_class;
         rsp_payload_in.protocol_number = protocol_in;
         rsp_payload_in.source_address  = source_in;
         rsp_payload_in.payload_offset  = header_bytes_in;
         rsp_payload_in.payload_length  = clamped_total - hdr_len_wide;
      end else begin
         rsp_payload_in.handler_class   = CLASS_OTHER;
         rsp_payload_in.protocol_number = '0;
         rsp_payload_in.source_address  = '0;
         rsp_payload_in.payload_offset  = '0;
         rsp_payload_in.payload_length  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.payload.data_byte;
         in_last_ff <= req_chan.payload.last_byte;
      end
      if (process && in_last_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end

      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         byte_count_ff   <= '0;
         header_bytes_ff <= '0;
         checksum_ff     <= '0;
         pending_ff      <= '0;
         total_ff        <= '0;
         protocol_ff     <= '0;
         source_ff       <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (process && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (process) begin
            if (in_last_ff) begin
               // end of packet: clear for the next one
               byte_count_ff   <= '0;
               header_bytes_ff <= '0;
               checksum_ff     <= '0;
               pending_ff      <= '0;
               total_ff        <= '0;
               protocol_ff     <= '0;
               source_ff       <= '0;
            end else begin
               byte_count_ff   <= byte_count_in;
               header_bytes_ff <= header_bytes_in;
               checksum_ff     <= checksum_in;
               pending_ff      <= pending_in;
               total_ff        <= total_in;
               protocol_ff     <= protocol_in;
               source_ff       <= source_in;
            end
         end
      end
   end

`ifndef SYNTH
   a_reject_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.verdict != VERDICT_ACCEPT |->
         rsp_payload_ff.handler_class == CLASS_OTHER && rsp_payload_ff.payload_offset == '0
         && rsp_payload_ff.payload_length == '0 && rsp_payload_ff.source_address == '0)
      else $error("rejected packet carries nonzero result fields");

   a_accept_min_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.verdict == VERDICT_ACCEPT |->
         {{(COUNT_W-HDR_LEN_W){1'b0}}, rsp_payload_ff.payload_offset} >= MIN_HEADER)
      else $error("accepted packet with header shorter than minimum");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      process && in_last_ff |=> byte_count_ff == '0 && checksum_ff == '0)
      else $error("packet state not cleared after final byte");

   a_middle_byte_no_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_last_ff |-> process)
      else $error("non-final byte stalled");

   a_last_fills_result: assert property (@(posedge clock) disable iff (reset)
      process && in_last_ff |=> rsp_valid_ff)
      else $error("final byte produced no result");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import ipv4_rhc_pkg::*;

   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned RANDOM_BYTES = 1100;

   typedef struct {
      int unsigned pkt_len;
      logic [7:0]  lead;
      logic [15:0] total;
      logic [7:0]  proto;
      logic [31:0] src;
      bit          csum_ok;
      bit          typed;
      verdict_type verdict;
   } packet_case_type;

   typedef struct {
      rsp_payload_type fields;
      bit              typed;
      verdict_type     typed_verdict;
   } verdict_expect_type;

   logic clock;
   logic reset;

   ipv4_rhc_req_if req_chan ();
   ipv4_rhc_rsp_if rsp_chan ();

   ipv4_receive_header_check uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   packet_case_type packet_cases [16] = '{
      '{1,     8'h00, 16'd0,     8'd0,       32'h00000000, 1'b1, 1'b1, VERDICT_SHORT},
      '{1,     8'hFF, 16'd0,     8'd0,       32'h00000000, 1'b1, 1'b1, VERDICT_SHORT},
      '{19,    8'h45, 16'd19,    PROTO_TCP,  32'hC0A80001, 1'b1, 1'b1, VERDICT_SHORT},
      '{20,    8'h45, 16'd20,    PROTO_ICMP, 32'h0A000001, 1'b1, 1'b1, VERDICT_ACCEPT},
      '{20,    8'h44, 16'd20,    PROTO_UDP,  32'h0A000002, 1'b1, 1'b1, VERDICT_BAD_IHL},
      '{20,    8'h40, 16'd20,    PROTO_UDP,  32'h0A000003, 1'b1, 1'b1, VERDICT_BAD_IHL},
      '{40,    8'h4F, 16'd40,    PROTO_TCP,  32'h0A000004, 1'b1, 1'b1, VERDICT_BAD_IHL},
      '{24,    8'h46, 16'd24,    PROTO_UDP,  32'hFFFFFFFF, 1'b1, 1'b1, VERDICT_ACCEPT},
      '{60,    8'h4F, 16'd60,    PROTO_TCP,  32'h00000000, 1'b1, 1'b1, VERDICT_ACCEPT},
      '{28,    8'h45, 16'd28,    PROTO_TCP,  32'hAC100001, 1'b0, 1'b1, VERDICT_BAD_CSUM},
      '{64,    8'h4F, 16'd64,    8'd2,       32'hAC100002, 1'b0, 1'b1, VERDICT_BAD_CSUM},
      '{30,    8'h46, 16'd20,    PROTO_TCP,  32'hAC100003, 1'b1, 1'b1, VERDICT_BAD_TOTAL},
      '{30,    8'h45, 16'd0,     PROTO_ICMP, 32'hAC100004, 1'b1, 1'b1, VERDICT_BAD_TOTAL},
      '{30,    8'h45, 16'hFFFF,  PROTO_UDP,  32'h7F000001, 1'b1, 1'b0, VERDICT_ACCEPT},
      '{21,    8'h45, 16'd20,    8'd255,     32'h80000000, 1'b1, 1'b0, VERDICT_ACCEPT},
      '{20,    8'hF5, 16'd20,    8'd0,       32'h01020304, 1'b1, 1'b1, VERDICT_ACCEPT}
   };

   logic [7:0]  pkt_bytes [];
   logic [15:0] pkt_count;
   logic [5:0]  pkt_hdr_len;
   logic [15:0] pkt_csum;
   logic [7:0]  pkt_word_hi;
   logic [15:0] pkt_total;
   logic [7:0]  pkt_proto;
   logic [31:0] pkt_src;

   verdict_expect_type outstanding_verdicts [$];
   verdict_expect_type oldest;
   bit              row_typed;
   verdict_type     row_verdict;
   bit              idle_on;
   bit              fault_seen;
   int unsigned     quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic fold_byte(input logic [7:0] b, input logic fin);
      logic [16:0]     acc;
      logic [15:0]     clamp;
      verdict_expect_type e;
      if (pkt_count == 16'd0) pkt_hdr_len = {b[3:0], 2'b00};
      if (pkt_count < pkt_hdr_len) begin
         if (!pkt_count[0]) begin
            pkt_word_hi = b;
         end else begin
            acc = {1'b0, pkt_csum} + {1'b0, pkt_word_hi, b};
            if (acc[16]) acc = acc[15:0] + 17'd1;
            pkt_csum = acc[15:0];
         end
      end
      if (pkt_count == IDX_TOTAL_HI) pkt_total[15:8] = b;
      else if (pkt_count == IDX_TOTAL_LO) pkt_total[7:0] = b;
      else if (pkt_count == IDX_PROTOCOL) pkt_proto = b;
      else if (pkt_count >= IDX_SRC_FIRST && pkt_count <= IDX_SRC_LAST)
         pkt_src = {pkt_src[23:0], b};
      if (pkt_count != COUNT_MAX) pkt_count = pkt_count + 16'd1;
      if (fin) begin
         clamp = (pkt_total > pkt_count) ? pkt_count : pkt_total;
         e.fields = '0;
         e.fields.handler_class = CLASS_OTHER;
         if (pkt_count < MIN_HEADER)
            e.fields.verdict = VERDICT_SHORT;
         else if (pkt_hdr_len < MIN_HEADER || pkt_hdr_len > pkt_count)
            e.fields.verdict = VERDICT_BAD_IHL;
         else if (pkt_csum != CSUM_GOOD)
            e.fields.verdict = VERDICT_BAD_CSUM;
         else if (clamp < pkt_hdr_len)
            e.fields.verdict = VERDICT_BAD_TOTAL;
         else begin
            e.fields.verdict = VERDICT_ACCEPT;
            case (pkt_proto)
               PROTO_ICMP: e.fields.handler_class = CLASS_ICMP;
               PROTO_UDP:  e.fields.handler_class = CLASS_UDP;
               PROTO_TCP:  e.fields.handler_class = CLASS_TCP;
               default:    e.fields.handler_class = CLASS_OTHER;
            endcase
            e.fields.protocol_number = pkt_proto;
            e.fields.source_address = pkt_src;
            e.fields.payload_offset = pkt_hdr_len;
            e.fields.payload_length = clamp - pkt_hdr_len;
         end
         e.typed = row_typed;
         e.typed_verdict = row_verdict;
         outstanding_verdicts.push_back(e);
         pkt_count = '0;
         pkt_hdr_len = '0;
         pkt_csum = '0;
         pkt_word_hi = '0;
         pkt_total = '0;
         pkt_proto = '0;
         pkt_src = '0;
      end
   endtask

   task automatic make_packet(input int unsigned len, input logic [7:0] lead,
                              input logic [15:0] total, input logic [7:0] proto,
                              input logic [31:0] src, input bit csum_ok);
      int unsigned hdr;
      logic [31:0] acc;
      pkt_bytes = new[len];
      foreach (pkt_bytes[i]) pkt_bytes[i] = 8'($urandom_range(0, 255));
      pkt_bytes[0] = lead;
      for (int i = 0; i < len && i < 16; i++) begin
         case (i)
            2:              pkt_bytes[i] = total[15:8];
            3:              pkt_bytes[i] = total[7:0];
            9:              pkt_bytes[i] = proto;
            12, 13, 14, 15: pkt_bytes[i] = src[8*(15-i) +: 8];
            default: ;
         endcase
      end
      hdr = lead[3:0] * 4;
      if (hdr >= 20 && hdr <= len) begin
         pkt_bytes[10] = 8'h00;
         pkt_bytes[11] = 8'h00;
         acc = '0;
         for (int i = 0; i < hdr; i += 2) acc += {pkt_bytes[i], pkt_bytes[i+1]};
         acc = acc[15:0] + acc[31:16];
         acc = acc[15:0] + acc[31:16];
         {pkt_bytes[10], pkt_bytes[11]} = ~acc[15:0];
         if (!csum_ok) pkt_bytes[10] ^= 8'h01;
      end
   endtask

   task automatic make_random_packet();
      int unsigned pick;
      int unsigned ihl;
      int unsigned len;
      logic [7:0]  lead;
      logic [15:0] total;
      logic [7:0]  proto;
      bit          csum_ok;
      pick = $urandom_range(0, 99);
      if (pick >= 85) begin
         pkt_bytes = new[$urandom_range(1, 30)];
         foreach (pkt_bytes[i]) pkt_bytes[i] = 8'($urandom_range(0, 255));
      end else begin
         ihl = ($urandom_range(0, 19) == 0) ? 15 : $urandom_range(5, 7);
         len = ihl * 4 + $urandom_range(0, 24);
         lead = {4'h4, 4'(ihl)};
         if ($urandom_range(0, 9) == 0) lead[7:4] = 4'($urandom_range(0, 15));
         total = 16'(len);
         case ($urandom_range(0, 9))
            0:       total = 16'(len + $urandom_range(1, 100));
            1:       total = 16'($urandom_range(ihl * 4, len));
            default: ;
         endcase
         case ($urandom_range(0, 3))
            0:       proto = PROTO_ICMP;
            1:       proto = PROTO_UDP;
            2:       proto = PROTO_TCP;
            default: proto = 8'($urandom_range(0, 255));
         endcase
         csum_ok = 1'b1;
         if (pick >= 70) begin
            case ($urandom_range(0, 4))
               0:       csum_ok = 1'b0;
               1:       lead[3:0] = 4'($urandom_range(0, 15));
               2:       total = 16'($urandom_range(0, 65535));
               3:       len = $urandom_range(1, len);
               default: total = 16'($urandom_range(0, ihl * 4 - 1));
            endcase
         end
         make_packet(len, lead, total, proto, $urandom, csum_ok);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= req_payload_type'{data_byte: b, last_byte: fin};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      fold_byte(b, fin);
   endtask

   task automatic send_packet(input bit typed, input verdict_type verdict);
      row_typed = typed;
      row_verdict = verdict;
      foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
   endtask

   // hold the sender until every outstanding verdict has been read
   task automatic drain_verdicts();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         fault_seen = 1'b1;
      end
   endtask

   initial begin
      int unsigned sent;
      idle_on = 1'b1;
      fault_seen = 1'b0;
      pkt_count = '0;
      pkt_hdr_len = '0;
      pkt_csum = '0;
      pkt_word_hi = '0;
      pkt_total = '0;
      pkt_proto = '0;
      pkt_src = '0;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (packet_cases[k]) begin
         idle_on = packet_cases[k].pkt_len < 1000;
         make_packet(packet_cases[k].pkt_len, packet_cases[k].lead, packet_cases[k].total,
                     packet_cases[k].proto, packet_cases[k].src, packet_cases[k].csum_ok);
         send_packet(packet_cases[k].typed, packet_cases[k].verdict);
      end
      drain_verdicts();
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         idle_on = $urandom_range(0, 7) != 0;
         make_random_packet();
         send_packet(1'b0, VERDICT_ACCEPT);
         sent += pkt_bytes.size();
         if ($urandom_range(0, 14) == 0) drain_verdicts();
      end
      drain_verdicts();
      repeat (10) @(posedge clock);
      if (!fault_seen)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_on ? $urandom_range(0, 6) : 0;
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (outstanding_verdicts.size() == 0) begin
            $error("verdict transaction with nothing outstanding");
            fault_seen = 1'b1;
         end else begin
            oldest = outstanding_verdicts.pop_front();
            check_field("verdict", oldest.fields.verdict, rsp_chan.payload.verdict);
            check_field("handler_class", oldest.fields.handler_class,
                        rsp_chan.payload.handler_class);
            check_field("protocol_number", oldest.fields.protocol_number,
                        rsp_chan.payload.protocol_number);
            check_field("source_address", oldest.fields.source_address,
                        rsp_chan.payload.source_address);
            check_field("payload_offset", oldest.fields.payload_offset,
                        rsp_chan.payload.payload_offset);
            check_field("payload_length", oldest.fields.payload_length,
                        rsp_chan.payload.payload_length);
            if (oldest.typed)
               check_field("verdict (table)", oldest.typed_verdict, rsp_chan.payload.verdict);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
